// ===== rtl/core/urxf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urxf_pkg
// Types, codes and constants shared by the UART receive FIFO framer.
// ----------------------------------------------------------------------------
package urxf_pkg;

  // Field widths of the words on the two channels.
  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int ERR_CNT_W = 16;

  // Configuration register widths and reset values.
  localparam int MAX_LEN_W   = 7;
  localparam int TIMEOUT_W   = 16;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 7'd64;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10;

  // A frame never exceeds POLL_LIMIT - 1 bytes.
  localparam int POLL_LIMIT = 64;
  localparam int CAP_W      = 6;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_MIN = 7'd2;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_MAX = MAX_LEN_W'(POLL_LIMIT);

  // The idle timer saturates instead of wrapping.
  localparam int IDLE_W = 17;
  localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

  localparam int DEFAULT_FIFO_DEPTH = 256;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_POLL = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_NO_DATA = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PENDING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BYTE    = 2'd2;

  // Configuration register indexes.
  localparam logic REG_MAX_LEN      = 1'b0;
  localparam logic REG_IDLE_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FETCH,
    ST_EMIT
  } state_t;

  // Outcome of a poll, worked out by the datapath.
  typedef enum logic [1:0] {
    PK_NO_DATA,
    PK_ARM,
    PK_PENDING,
    PK_DELIVER
  } poll_kind_t;

  typedef struct packed {
    logic take;
    logic decide_load;
    logic arm;
    logic start_deliver;
    logic fetch;
    logic emit_load;
  } urxf_cmd_t;

  typedef struct packed {
    poll_kind_t kind;
    logic       out_free;
    logic       remaining_zero;
  } urxf_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/urxf_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urxf_if
// Valid/ready channels for the framer: input operations and result words.
// ----------------------------------------------------------------------------

// Input channel: one operation word per handshake.
interface urxf_in_if import urxf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] rx_char;
  logic              overrun_flag;
  logic              framing_flag;

  modport source (output valid, operation, rx_char, overrun_flag, framing_flag,
                  input ready);
  modport sink (input valid, operation, rx_char, overrun_flag, framing_flag,
                output ready);
endinterface

// Output channel: one result word per handshake.
interface urxf_out_if import urxf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [CHAR_W-1:0]    frame_byte;
  logic                 last;
  logic [ERR_CNT_W-1:0] overrun_count;
  logic [ERR_CNT_W-1:0] framing_count;
  logic [ERR_CNT_W-1:0] dropped_count;

  modport source (output valid, status, frame_byte, last, overrun_count,
                  framing_count, dropped_count, input ready);
  modport sink (input valid, status, frame_byte, last, overrun_count,
                framing_count, dropped_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/uart_rx_fifo_idle_framer.sv =====
`default_nettype none
// Character and tick words keep the controller idle: a new word is taken every
// cycle until a poll is taken. A poll's status word, or each frame byte after
// its store read, is loaded into the output register once that is free. The
// next word is taken after the frame's last byte is loaded for output. Reset
// clears pointers, fill level, timer, counters, config registers and output
// valid; the store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// uart_rx_fifo_idle_framer
// UART receive FIFO that closes frames on an idle timeout or on overfill.
// ----------------------------------------------------------------------------
module uart_rx_fifo_idle_framer import urxf_pkg::*; #(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  urxf_in_if.sink                    in_ch,
  urxf_out_if.source                 out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  urxf_cmd_t cmd;
  urxf_sts_t sts;

  assign pready = 1'b1;

  // Controller.
  urxf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_is_poll (in_ch.operation == OP_POLL),
    .in_ready   (in_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath.
  urxf_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (in_ch.operation),
    .rx_char       (in_ch.rx_char),
    .overrun_flag  (in_ch.overrun_flag),
    .framing_flag  (in_ch.framing_flag),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .status        (out_ch.status),
    .frame_byte    (out_ch.frame_byte),
    .last          (out_ch.last),
    .overrun_count (out_ch.overrun_count),
    .framing_count (out_ch.framing_count),
    .dropped_count (out_ch.dropped_count),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
  );

`ifndef SYNTHESIS
  // A taken poll holds off further words until its last result word is loaded.
  a_poll_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && (in_ch.operation == OP_POLL)) |=> !in_ch.ready)
    else $error("input taken in the cycle after a poll");

  // Only a delivered frame byte can close a frame.
  a_last_is_byte: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.last) |-> (out_ch.status == STATUS_BYTE))
    else $error("last marked on a status word");

  // Status words carry no byte.
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status != STATUS_BYTE)) |-> (out_ch.frame_byte == '0))
    else $error("status word carries a byte");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/urxf_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urxf_datapath
// FIFO store, pointers, counters, idle timer, poll decision, output register
// and configuration registers.
// ----------------------------------------------------------------------------
module urxf_datapath import urxf_pkg::*; #(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire urxf_cmd_t             cmd,
  output urxf_sts_t                  sts,
  input  wire logic [OP_W-1:0]       operation,
  input  wire logic [CHAR_W-1:0]     rx_char,
  input  wire logic                  overrun_flag,
  input  wire logic                  framing_flag,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        status,
  output logic [CHAR_W-1:0]          frame_byte,
  output logic                       last,
  output logic [ERR_CNT_W-1:0]       overrun_count,
  output logic [ERR_CNT_W-1:0]       framing_count,
  output logic [ERR_CNT_W-1:0]       dropped_count,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CMP_W = (PTR_W > CAP_W) ? PTR_W : CAP_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [PTR_W-1:0] USABLE   = PTR_W'(FIFO_DEPTH - 1);

  logic [CHAR_W-1:0]    mem [FIFO_DEPTH];
  logic [CHAR_W-1:0]    rd_data;
  logic [PTR_W-1:0]     read_ptr;
  logic [PTR_W-1:0]     write_ptr;
  logic [PTR_W-1:0]     fill_count;
  logic [PTR_W-1:0]     fill_at_last_poll;
  logic [IDLE_W-1:0]    idle_elapsed;
  logic [ERR_CNT_W-1:0] overrun_errors;
  logic [ERR_CNT_W-1:0] framing_errors;
  logic [ERR_CNT_W-1:0] dropped_chars;
  logic [CAP_W-1:0]     remaining;
  logic [MAX_LEN_W-1:0] max_len;
  logic [TIMEOUT_W-1:0] idle_timeout_ms;

  logic                 cfg_we;
  logic                 char_store;
  logic [MAX_LEN_W-1:0] ml_clamped;
  logic [CAP_W-1:0]     cap;
  logic [CMP_W-1:0]     fill_ext;
  logic [CMP_W-1:0]     cap_ext;
  logic                 fill_over_cap;
  logic [CAP_W-1:0]     deliver_len;
  poll_kind_t           poll_kind;

  // Configuration registers, written on the access phase of an APB write.
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len         <= MAX_LEN_RESET;
      idle_timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_MAX_LEN) begin
        max_len <= pwdata[MAX_LEN_W-1:0];
      end else begin
        idle_timeout_ms <= pwdata[TIMEOUT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_IDLE_TIMEOUT) begin
      prdata = {{(APB_DATA_W-TIMEOUT_W){1'b0}}, idle_timeout_ms};
    end else begin
      prdata = {{(APB_DATA_W-MAX_LEN_W){1'b0}}, max_len};
    end
  end

  // A character is stored only when clean and when the FIFO has room.
  assign char_store = cmd.take && (operation == OP_CHAR) && !overrun_flag &&
                      !framing_flag && (fill_count < USABLE);

  // Store write port.
  always_ff @(posedge clk) begin
    if (char_store) begin
      mem[write_ptr] <= rx_char;
    end
  end

  // Store read port, registered.
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_data <= mem[read_ptr];
    end
  end

  // Pointers, fill level and the snapshot taken at the last poll.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr          <= '0;
      write_ptr         <= '0;
      fill_count        <= '0;
      fill_at_last_poll <= '0;
    end else begin
      if (char_store) begin
        write_ptr  <= (write_ptr == PTR_LAST) ? '0 : write_ptr + 1'b1;
        fill_count <= fill_count + 1'b1;
      end else if (cmd.fetch) begin
        fill_count <= fill_count - 1'b1;
      end
      if (cmd.fetch) begin
        read_ptr <= (read_ptr == PTR_LAST) ? '0 : read_ptr + 1'b1;
      end
      if (cmd.arm) begin
        fill_at_last_poll <= fill_count;
      end else if (cmd.start_deliver) begin
        fill_at_last_poll <= '0;
      end
    end
  end

  // Error counters wrap; an overrun takes precedence over a framing error.
  always_ff @(posedge clk) begin
    if (rst) begin
      overrun_errors <= '0;
      framing_errors <= '0;
      dropped_chars  <= '0;
    end else if (cmd.take && (operation == OP_CHAR)) begin
      if (overrun_flag) begin
        overrun_errors <= overrun_errors + 1'b1;
      end else if (framing_flag) begin
        framing_errors <= framing_errors + 1'b1;
      end else if (fill_count >= USABLE) begin
        dropped_chars <= dropped_chars + 1'b1;
      end
    end
  end

  // Idle timer: ages on ticks, saturates, restarts when a poll arms it.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_elapsed <= '0;
    end else if (cmd.arm) begin
      idle_elapsed <= '0;
    end else if (cmd.take && (operation == OP_TICK) && (idle_elapsed != IDLE_MAX)) begin
      idle_elapsed <= idle_elapsed + 1'b1;
    end
  end

  // Poll decision from the current fill level and timer.
  always_comb begin
    if (max_len < MAX_LEN_MIN) begin
      ml_clamped = MAX_LEN_MIN;
    end else if (max_len > MAX_LEN_MAX) begin
      ml_clamped = MAX_LEN_MAX;
    end else begin
      ml_clamped = max_len;
    end
    cap           = CAP_W'(ml_clamped - 1'b1);
    fill_ext      = CMP_W'(fill_count);
    cap_ext       = CMP_W'(cap);
    fill_over_cap = fill_ext > cap_ext;
    deliver_len   = fill_over_cap ? cap : CAP_W'(fill_ext);

    if (fill_count == '0) begin
      poll_kind = PK_NO_DATA;
    end else if (fill_at_last_poll != fill_count) begin
      poll_kind = fill_over_cap ? PK_DELIVER : PK_ARM;
    end else if (idle_elapsed > IDLE_W'(idle_timeout_ms)) begin
      poll_kind = PK_DELIVER;
    end else begin
      poll_kind = PK_PENDING;
    end
  end

  // Bytes still to fetch in the frame being delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (cmd.start_deliver) begin
      remaining <= deliver_len;
    end else if (cmd.fetch) begin
      remaining <= remaining - 1'b1;
    end
  end

  assign sts.kind           = poll_kind;
  assign sts.remaining_zero = (remaining == '0);
  assign sts.out_free       = !out_valid || out_ready;

  // Output register: holds one result word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.decide_load || cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide_load) begin
      status     <= (poll_kind == PK_NO_DATA) ? STATUS_NO_DATA : STATUS_PENDING;
      frame_byte <= '0;
      last       <= 1'b0;
    end else if (cmd.emit_load) begin
      status     <= STATUS_BYTE;
      frame_byte <= rd_data;
      last       <= sts.remaining_zero;
    end
    if (cmd.decide_load || cmd.emit_load) begin
      overrun_count <= overrun_errors;
      framing_count <= framing_errors;
      dropped_count <= dropped_chars;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/urxf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urxf_ctrl
// Controller: takes operation words and sequences poll results and frame
// delivery through the datapath.
// ----------------------------------------------------------------------------
module urxf_ctrl import urxf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_is_poll,
  output logic           in_ready,
  input  wire urxf_sts_t sts,
  output urxf_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_is_poll) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.out_free) begin
          state_next = (sts.kind == PK_DELIVER) ? ST_FETCH : ST_IDLE;
        end
      end
      ST_FETCH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_next = sts.remaining_zero ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_DECIDE: begin
        if (sts.out_free) begin
          if (sts.kind == PK_DELIVER) begin
            cmd.start_deliver = 1'b1;
          end else begin
            cmd.decide_load = 1'b1;
            cmd.arm         = (sts.kind == PK_ARM);
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_uart_rx_fifo_idle_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_rx_fifo_idle_framer
// Self-checking bench for the UART receive FIFO with idle-timeout framing.
// The bench feeds character, tick and poll words over the input channel. It
// keeps its own model of the FIFO, the idle timer and the error counters, and
// checks every result word against that model, field by field. Both channels
// idle at random. The register port is written between phases, and each write
// is read back.
// ----------------------------------------------------------------------------
module tb_uart_rx_fifo_idle_framer;
  import urxf_pkg::*;

  localparam int FIFO_DEPTH = DEFAULT_FIFO_DEPTH;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RESET_CYCLES    = 9;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int MAX_REPORTS     = 40;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 6;
  localparam int HOLD_CYCLES     = 600;
  localparam int FILL_CHARS      = FIFO_DEPTH + 2;

  // One word for the input channel.
  typedef struct {
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] rx_char;
    logic              overrun_flag;
    logic              framing_flag;
    bit                nogap;
  } uart_op_t;

  // One word from the output channel.
  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [CHAR_W-1:0]    frame_byte;
    logic                 last;
    logic [ERR_CNT_W-1:0] overrun_count;
    logic [ERR_CNT_W-1:0] framing_count;
    logic [ERR_CNT_W-1:0] dropped_count;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  urxf_in_if  in_ch ();
  urxf_out_if out_ch ();

  uart_rx_fifo_idle_framer i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Words waiting to be sent, and result words still due from the block.
  uart_op_t    op_queue[$];
  frame_word_t due_words[$];

  // Model state.
  logic [CHAR_W-1:0]    fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W:0]       fill_level;
  logic [PTR_W:0]       fill_at_poll;
  logic [IDLE_W-1:0]    idle_ms;
  logic [ERR_CNT_W-1:0] overrun_errs;
  logic [ERR_CNT_W-1:0] framing_errs;
  logic [ERR_CNT_W-1:0] dropped_chars;
  logic [MAX_LEN_W-1:0] cfg_max_len;
  logic [TIMEOUT_W-1:0] cfg_timeout;

  // Handshake bookkeeping between the clock edges.
  uart_op_t cur_op;
  bit       offering;
  bit       in_fire;
  bit       out_fire;
  bit       src_idle_on;
  bit       sink_idle_on;
  int       gap_left;
  int       stall_left;
  int       hold_left;
  int       mismatch_count;
  int       cycle_count;

  // Queue a result word carrying the current error counts.
  function automatic void push_word(logic [STATUS_W-1:0] status, logic [CHAR_W-1:0] frame_byte,
                                    logic last);
    frame_word_t w;
    w.status        = status;
    w.frame_byte    = frame_byte;
    w.last          = last;
    w.overrun_count = overrun_errs;
    w.framing_count = framing_errs;
    w.dropped_count = dropped_chars;
    due_words.push_back(w);
  endfunction

  // Hand n bytes out of the FIFO as one frame.
  function automatic void deliver_frame(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      push_word(STATUS_BYTE, fifo_mem[rd_ptr], (i + 1 == n));
      rd_ptr++;
      fill_level--;
    end
    fill_at_poll = '0;
  endfunction

  // Advance the model by one accepted word and queue the words it causes.
  function automatic void framer_predict(uart_op_t op);
    int unsigned ml;
    int unsigned cap;
    ml = cfg_max_len;
    if (ml < MAX_LEN_MIN) ml = MAX_LEN_MIN;
    if (ml > MAX_LEN_MAX) ml = MAX_LEN_MAX;
    cap = ml - 1;
    case (op.operation)
      OP_CHAR: begin
        if (op.overrun_flag) overrun_errs++;
        else if (op.framing_flag) framing_errs++;
        else if (fill_level >= FIFO_DEPTH - 1) dropped_chars++;
        else begin
          fifo_mem[wr_ptr] = op.rx_char;
          wr_ptr++;
          fill_level++;
        end
      end
      OP_TICK: begin
        if (idle_ms != IDLE_MAX) idle_ms++;
      end
      OP_POLL: begin
        if (fill_level == 0) begin
          push_word(STATUS_NO_DATA, '0, 1'b0);
        end else if (fill_at_poll != fill_level) begin
          if (fill_level > cap) begin
            deliver_frame(cap);
          end else begin
            // Fill has moved on: restart the silence measurement.
            fill_at_poll = fill_level;
            idle_ms = '0;
            push_word(STATUS_PENDING, '0, 1'b0);
          end
        end else if (idle_ms > cfg_timeout) begin
          deliver_frame((fill_level > cap) ? cap : fill_level);
        end else begin
          push_word(STATUS_PENDING, '0, 1'b0);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_op(logic [OP_W-1:0] operation, logic [CHAR_W-1:0] rx_char,
                                   logic overrun_flag, logic framing_flag, bit nogap);
    uart_op_t op;
    op.operation    = operation;
    op.rx_char      = rx_char;
    op.overrun_flag = overrun_flag;
    op.framing_flag = framing_flag;
    op.nogap        = nogap;
    op_queue.push_back(op);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Queue one random burst; returns how many words count as stimulus.
  // Most bursts are a frame: characters, a poll, some silence and a poll.
  function automatic int queue_random_burst();
    int n;
    int ticks;
    int added;
    logic [OP_W-1:0] op;
    added = 0;
    if ($urandom_range(0, 4) != 0) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 12);
      for (int i = 0; i < n; i++)
        queue_op(OP_CHAR, CHAR_W'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0),
                 ($urandom_range(0, 9) == 0), 1'b0);
      queue_op(OP_POLL, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'b0);
      ticks = $urandom_range(0, cfg_timeout + 2);
      for (int i = 0; i < ticks; i++)
        queue_op(OP_TICK, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'b0);
      queue_op(OP_POLL, 8'h00, 1'b0, 1'b0, 1'b0);
      added = n + ticks + 2;
      if ($urandom_range(0, 1) == 1) begin
        for (int i = 0; i <= cfg_timeout; i++) queue_op(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_op(OP_POLL, 8'h00, 1'b0, 1'b0, 1'b0);
        added += cfg_timeout + 2;
      end
    end else begin
      // Noise: any operation with any content, unused code included.
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        op = OP_W'($urandom_range(0, 3));
        queue_op(op, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'b0);
        if (op != OP_UNUSED) added++;
      end
    end
    return added;
  endfunction

  // Register write followed by a read-back; the model copy follows the write.
  task automatic set_reg(logic idx, logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * idx);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_MAX_LEN) cfg_max_len = value[MAX_LEN_W-1:0];
    else cfg_timeout = value[TIMEOUT_W-1:0];
    check_field("register read-back", value, got);
  endtask

  // Wait until every queued word is sent and every due word has come back.
  task automatic wait_for_drain();
    while (op_queue.size() != 0 || offering || due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Input side: note an accepted word and predict what it causes.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      framer_predict(cur_op);
      in_fire = 1'b1;
    end
  end

  // Input driver: offer the next queued word after a random gap.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire) begin
        in_fire  = 1'b0;
        offering = 1'b0;
        gap_left = (src_idle_on && !cur_op.nogap) ? $urandom_range(0, 15) : 0;
      end
      if (!offering) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (op_queue.size() != 0) begin
          cur_op   = op_queue.pop_front();
          offering = 1'b1;
        end
      end
      in_ch.valid        <= offering;
      in_ch.operation    <= cur_op.operation;
      in_ch.rx_char      <= cur_op.rx_char;
      in_ch.overrun_flag <= cur_op.overrun_flag;
      in_ch.framing_flag <= cur_op.framing_flag;
    end
  end

  // Output side: compare each accepted word with the oldest one due.
  always @(posedge clk) begin
    frame_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      out_fire = 1'b1;
      if (due_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t ns: word expected none, got status %0d byte %0d", $time,
                   out_ch.status, out_ch.frame_byte);
      end else begin
        want = due_words.pop_front();
        check_field("status", want.status, out_ch.status);
        check_field("frame_byte", want.frame_byte, out_ch.frame_byte);
        check_field("last", want.last, out_ch.last);
        check_field("overrun_count", want.overrun_count, out_ch.overrun_count);
        check_field("framing_count", want.framing_count, out_ch.framing_count);
        check_field("dropped_count", want.dropped_count, out_ch.dropped_count);
      end
    end
  end

  // Output ready: random stall after each word, and the long hold-off.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_fire) begin
        out_fire   = 1'b0;
        stall_left = sink_idle_on ? $urandom_range(0, 15) : 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ch.ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  // The long hold-off counts down on its own.
  always @(posedge clk) begin
    if (hold_left != 0) hold_left--;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int counted;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_CHAR;
    in_ch.rx_char      = '0;
    in_ch.overrun_flag = 1'b0;
    in_ch.framing_flag = 1'b0;
    out_ch.ready       = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rd_ptr        = '0;
    wr_ptr        = '0;
    fill_level    = '0;
    fill_at_poll  = '0;
    idle_ms       = '0;
    overrun_errs  = '0;
    framing_errs  = '0;
    dropped_chars = '0;
    cfg_max_len   = MAX_LEN_RESET;
    cfg_timeout   = TIMEOUT_RESET;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words under the reset settings: empty poll, extreme characters,
    // each error flag alone and together, the unused code, then a frame closed
    // by silence.
    queue_op(OP_POLL, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_op(OP_CHAR, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_op(OP_CHAR, 8'hFF, 1'b0, 1'b0, 1'b0);
    queue_op(OP_CHAR, 8'h5A, 1'b1, 1'b0, 1'b0);
    queue_op(OP_CHAR, 8'hA5, 1'b0, 1'b1, 1'b0);
    queue_op(OP_CHAR, 8'h3C, 1'b1, 1'b1, 1'b0);
    queue_op(OP_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b0);
    queue_op(OP_CHAR, 8'hA5, 1'b0, 1'b0, 1'b0);
    queue_op(OP_POLL, 8'hFF, 1'b1, 1'b1, 1'b0);
    queue_op(OP_POLL, 8'h00, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i <= TIMEOUT_RESET; i++) queue_op(OP_TICK, 8'hFF, 1'b1, 1'b1, 1'b0);
    queue_op(OP_POLL, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_op(OP_POLL, 8'h00, 1'b0, 1'b0, 1'b0);
    wait_for_drain();

    // Random phases, each under its own settings, out-of-range lengths included.
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        0: begin set_reg(REG_MAX_LEN, 32'd2);   set_reg(REG_IDLE_TIMEOUT, 32'd0); end
        1: begin set_reg(REG_MAX_LEN, 32'd127); set_reg(REG_IDLE_TIMEOUT, 32'd3); end
        2: begin set_reg(REG_MAX_LEN, 32'd0);   set_reg(REG_IDLE_TIMEOUT, 32'd7); end
        3: begin set_reg(REG_MAX_LEN, 32'd1);   set_reg(REG_IDLE_TIMEOUT, 32'd1); end
        4: begin
          set_reg(REG_MAX_LEN, $urandom_range(3, 63));
          set_reg(REG_IDLE_TIMEOUT, $urandom_range(0, 20));
        end
        default: begin
          set_reg(REG_MAX_LEN, 32'd65);
          set_reg(REG_IDLE_TIMEOUT, $urandom_range(0, 20));
        end
      endcase
      src_idle_on  = (k % 3 != 1);
      sink_idle_on = (k % 4 != 2);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) counted += queue_random_burst();
      wait_for_drain();
    end

    // Fill the FIFO past full while the output is held off, so that the
    // polls back up behind a stuck result and the input stalls.
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    set_reg(REG_MAX_LEN, 32'd100);
    set_reg(REG_IDLE_TIMEOUT, 32'd10);
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < FILL_CHARS; i++)
      queue_op(OP_CHAR, CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
    repeat (5) queue_op(OP_POLL, 8'h00, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i <= 10; i++) queue_op(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_op(OP_POLL, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_op(OP_POLL, 8'h00, 1'b0, 1'b0, 1'b0);
    wait_for_drain();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
